// ----- hdl/bsa_pkg.sv -----
`default_nettype none
package bsa_pkg;

  // item field widths
  localparam int CW   = 32;
  localparam int BW   = 21;
  localparam int TOLW = 17;
  localparam int AW   = 31;

  localparam logic [TOLW-1:0] TOL_RESET = 17'd1;

  // internal widths
  localparam int DXW  = CW + 1;        // coordinate difference
  localparam int SQW  = 34;            // chord length root bits
  localparam int SSW  = 2 * SQW;       // radicand bits
  localparam int REMW = SQW + 3;       // root remainder
  localparam int FW   = 41;            // 2^32 +/- bulge^2 magnitude
  localparam int DW   = 39;            // divisor (bulge << 18)
  localparam int RW   = DW + 1;        // division remainder
  localparam int QW   = 46;            // quotient bits
  localparam int PW   = 75;            // dividend bits
  localparam int LOW  = 21;            // low slice of the wide multiplicand
  localparam int CXW  = 48;            // wide center
  localparam int VW   = CXW + 1;       // center to point vector
  localparam int VMW  = VW - 1;        // vector magnitude
  localparam int PSW  = 6;             // leading one position
  localparam int NORM_MSB = 29;        // magnitude lands in [2^29, 2^30)
  localparam int NMW  = NORM_MSB + 1;
  localparam int CRW  = 33;            // rotator x/y
  localparam int ZW   = 32;            // angle accumulator
  localparam int ATW  = 28;
  localparam int CORDIC_STEPS = 28;

  localparam int NPIPE = 3 + SQW + 2 + QW + 2 + 3 + CORDIC_STEPS;

  localparam logic signed [ZW-1:0] ANG_PI     = 32'sd843314857;
  localparam logic signed [ZW-1:0] ANG_TWO_PI = 32'sd1686629713;

  // arctan(2^-i) in Q3.28
  function automatic logic [ATW-1:0] atan_val(input int i);
    logic [ATW-1:0] v;
    case (i)
      0:       v = 28'd210828714;
      1:       v = 28'd124459457;
      2:       v = 28'd65760959;
      3:       v = 28'd33381290;
      4:       v = 28'd16755422;
      5:       v = 28'd8385879;
      6:       v = 28'd4193963;
      7:       v = 28'd2097109;
      8:       v = 28'd1048571;
      9:       v = 28'd524287;
      default: v = ATW'(28'd262144 >> (i - 10));
    endcase
    return v;
  endfunction

  typedef struct packed {
    logic [SSW-1:0]  rad;
    logic [REMW-1:0] rem;
    logic [SQW-1:0]  root;
  } sqrt_t;

  typedef struct packed {
    logic [QW-1:0] num;
    logic [RW-1:0] rem;
    logic [QW-1:0] q;
  } div_t;

  typedef struct packed {
    div_t r;
    div_t x;
    div_t y;
  } div3_t;

  typedef struct packed {
    logic signed [CRW-1:0] px;
    logic signed [CRW-1:0] py;
    logic signed [ZW-1:0]  z;
  } cordic_t;

  typedef struct packed {
    cordic_t s;
    cordic_t e;
  } cordic2_t;

  // per-item data that rides beside the root and divide chains
  typedef struct packed {
    logic                  is_arc;
    logic                  bneg;
    logic signed [CW-1:0]  sx;
    logic signed [CW-1:0]  sy;
    logic signed [CW-1:0]  ex;
    logic signed [CW-1:0]  ey;
    logic signed [DXW-1:0] midx;
    logic signed [DXW-1:0] midy;
    logic [DXW-1:0]        adx;
    logic [DXW-1:0]        ady;
    logic                  negx;
    logic                  negy;
    logic [FW-1:0]         nmag;
    logic [FW-1:0]         fac;
    logic [DW-1:0]         den;
    logic                  rovf;
  } side_t;

  // per-item data that rides beside the rotator chain
  typedef struct packed {
    logic                 is_arc;
    logic                 bneg;
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
    logic signed [CW-1:0] ex;
    logic signed [CW-1:0] ey;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic [CW-1:0]        rad;
    logic                 ovf;
    logic [1:0]           zero;
    logic [1:0]           flip;
  } late_t;

  typedef struct packed {
    logic                 is_arc;
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
    logic signed [CW-1:0] ex;
    logic signed [CW-1:0] ey;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic [CW-1:0]        rad;
    logic [AW-1:0]        sa;
    logic [AW-1:0]        ea;
    logic                 rev;
    logic                 ovf;
  } res_t;

endpackage
`default_nettype wire

// ----- hdl/bsa_if.sv -----
`default_nettype none
interface bsa_seg_if;
  logic                          valid;
  logic                          ready;
  logic signed [bsa_pkg::CW-1:0] anchor_x;
  logic signed [bsa_pkg::CW-1:0] anchor_y;
  logic signed [bsa_pkg::CW-1:0] vertex_x;
  logic signed [bsa_pkg::CW-1:0] vertex_y;
  logic signed [bsa_pkg::BW-1:0] bulge;
  logic                          prepend;

  modport source (output valid, anchor_x, anchor_y, vertex_x, vertex_y, bulge, prepend,
                  input ready);
  modport sink (input valid, anchor_x, anchor_y, vertex_x, vertex_y, bulge, prepend,
                output ready);
endinterface

interface bsa_arc_if;
  logic                          valid;
  logic                          ready;
  logic                          is_arc;
  logic signed [bsa_pkg::CW-1:0] seg_start_x;
  logic signed [bsa_pkg::CW-1:0] seg_start_y;
  logic signed [bsa_pkg::CW-1:0] seg_end_x;
  logic signed [bsa_pkg::CW-1:0] seg_end_y;
  logic signed [bsa_pkg::CW-1:0] center_x;
  logic signed [bsa_pkg::CW-1:0] center_y;
  logic [bsa_pkg::CW-1:0]        radius;
  logic [bsa_pkg::AW-1:0]        start_angle;
  logic [bsa_pkg::AW-1:0]        end_angle;
  logic                          reversed;
  logic                          overflow;

  modport source (output valid, is_arc, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
                  center_x, center_y, radius, start_angle, end_angle, reversed, overflow,
                  input ready);
  modport sink (input valid, is_arc, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
                center_x, center_y, radius, start_angle, end_angle, reversed, overflow,
                output ready);
endinterface
`default_nettype wire

// ----- hdl/bulge_segment_to_arc.sv -----
// Bulge segment to arc: fully pipelined, one segment word accepted per clock unless
// the output stalls. The pipe has 3 setup stages, a 34-cell root chain, 2 multiply
// stages, a 46-cell divide chain, 5 center and normalize stages and a 28-cell
// rotator chain, then an output register; the whole pipe holds on stall.
// Reset clears all valid bits and sets line_tolerance to 1; no clearing pass.
`default_nettype none
module bulge_segment_to_arc (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [bsa_pkg::TOLW-1:0]     cfg_wdata_i,
  bsa_seg_if.sink                      seg_i,
  bsa_arc_if.source                    arc_o
);

  localparam int SQW = bsa_pkg::SQW;
  localparam int QW  = bsa_pkg::QW;
  localparam int NS  = bsa_pkg::CORDIC_STEPS;
  localparam int NP  = bsa_pkg::NPIPE;

  typedef struct packed {
    logic                           is_arc;
    logic                           bneg;
    logic signed [bsa_pkg::CW-1:0]  sx;
    logic signed [bsa_pkg::CW-1:0]  sy;
    logic signed [bsa_pkg::CW-1:0]  ex;
    logic signed [bsa_pkg::CW-1:0]  ey;
    logic signed [bsa_pkg::DXW-1:0] dx;
    logic signed [bsa_pkg::DXW-1:0] dy;
    logic signed [bsa_pkg::DXW-1:0] midx;
    logic signed [bsa_pkg::DXW-1:0] midy;
    logic [bsa_pkg::BW-1:0]         mb;
  } p1_t;

  typedef struct packed {
    logic                           is_arc;
    logic                           bneg;
    logic signed [bsa_pkg::CW-1:0]  sx;
    logic signed [bsa_pkg::CW-1:0]  sy;
    logic signed [bsa_pkg::CW-1:0]  ex;
    logic signed [bsa_pkg::CW-1:0]  ey;
    logic signed [bsa_pkg::DXW-1:0] midx;
    logic signed [bsa_pkg::DXW-1:0] midy;
    logic [bsa_pkg::DXW-1:0]        adx;
    logic [bsa_pkg::DXW-1:0]        ady;
    logic                           dypos;
    logic                           dxneg;
    logic [2*bsa_pkg::DXW-1:0]      dx2;
    logic [2*bsa_pkg::DXW-1:0]      dy2;
    logic [bsa_pkg::BW-1:0]         mb;
    logic [bsa_pkg::FW-1:0]         mb2;
  } p2_t;

  typedef struct packed {
    bsa_pkg::side_t                          sd;
    logic [SQW+bsa_pkg::LOW-1:0]             r_lo;
    logic [SQW+bsa_pkg::FW-bsa_pkg::LOW-1:0] r_hi;
    logic [SQW+bsa_pkg::LOW-1:0]             x_lo;
    logic [SQW+bsa_pkg::FW-bsa_pkg::LOW-1:0] x_hi;
    logic [SQW+bsa_pkg::LOW-1:0]             y_lo;
    logic [SQW+bsa_pkg::FW-bsa_pkg::LOW-1:0] y_hi;
  } m1_t;

  typedef struct packed {
    bsa_pkg::late_t                  lt;
    logic signed [bsa_pkg::CXW-1:0]  cxw;
    logic signed [bsa_pkg::CXW-1:0]  cyw;
  } c1_t;

  typedef struct packed {
    bsa_pkg::late_t                          lt;
    logic [1:0][bsa_pkg::VW-1:0]             vx;
    logic [1:0][bsa_pkg::VW-1:0]             vy;
  } c2_t;

  typedef struct packed {
    bsa_pkg::late_t                  lt;
    logic [1:0][bsa_pkg::VMW-1:0]    ax;
    logic [1:0][bsa_pkg::VMW-1:0]    ay;
    logic [1:0]                      xn;
    logic [1:0]                      yn;
  } n1_t;

  typedef struct packed {
    bsa_pkg::late_t                  lt;
    logic [1:0][bsa_pkg::VMW-1:0]    ax;
    logic [1:0][bsa_pkg::VMW-1:0]    ay;
    logic [1:0]                      xn;
    logic [1:0]                      yn;
    logic [1:0][bsa_pkg::PSW-1:0]    pos;
  } n2_t;

  // ---------------------------------------------------------------- handshake
  logic                   adv;
  logic                   in_fire;
  logic [NP-1:0]          vld_q;
  logic                   out_vld_q;
  bsa_pkg::res_t          out_d, out_q;
  logic [bsa_pkg::TOLW-1:0] tol_q;

  assign adv         = !out_vld_q || arc_o.ready;
  assign seg_i.ready = adv;
  assign in_fire     = seg_i.valid && adv;

  // hold tolerance register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= bsa_pkg::TOL_RESET;
    end else if (cfg_we_i) begin
      tol_q <= cfg_wdata_i;
    end
  end

  // shift valid bits through the pipe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q     <= {vld_q[NP-2:0], in_fire};
      out_vld_q <= vld_q[NP-1];
    end
  end

  // ---------------------------------------------------------------- setup
  p1_t p1_d, p1_q;
  p2_t p2_d, p2_q;
  bsa_pkg::side_t sd3_d, sd3_q;
  bsa_pkg::sqrt_t sq_init;
  logic [bsa_pkg::DXW-1:0] sumx, sumy;
  logic signed [bsa_pkg::FW:0] nv;
  logic nneg;

  // order endpoints, chord deltas, midpoint, line test
  always_comb begin
    p1_d.sx   = seg_i.prepend ? seg_i.vertex_x : seg_i.anchor_x;
    p1_d.sy   = seg_i.prepend ? seg_i.vertex_y : seg_i.anchor_y;
    p1_d.ex   = seg_i.prepend ? seg_i.anchor_x : seg_i.vertex_x;
    p1_d.ey   = seg_i.prepend ? seg_i.anchor_y : seg_i.vertex_y;
    p1_d.bneg = seg_i.bulge[bsa_pkg::BW-1];
    p1_d.mb   = p1_d.bneg ? -seg_i.bulge : seg_i.bulge;
    p1_d.is_arc = !(p1_d.mb < {{(bsa_pkg::BW - bsa_pkg::TOLW){1'b0}}, tol_q} ||
                    p1_d.mb == '0);
    p1_d.dx   = {p1_d.ex[bsa_pkg::CW-1], p1_d.ex} - {p1_d.sx[bsa_pkg::CW-1], p1_d.sx};
    p1_d.dy   = {p1_d.ey[bsa_pkg::CW-1], p1_d.ey} - {p1_d.sy[bsa_pkg::CW-1], p1_d.sy};
    sumx      = {p1_d.sx[bsa_pkg::CW-1], p1_d.sx} + {p1_d.ex[bsa_pkg::CW-1], p1_d.ex};
    sumy      = {p1_d.sy[bsa_pkg::CW-1], p1_d.sy} + {p1_d.ey[bsa_pkg::CW-1], p1_d.ey};
    p1_d.midx = $signed(sumx + {{(bsa_pkg::DXW-1){1'b0}}, sumx[bsa_pkg::DXW-1]}) >>> 1;
    p1_d.midy = $signed(sumy + {{(bsa_pkg::DXW-1){1'b0}}, sumy[bsa_pkg::DXW-1]}) >>> 1;
  end

  // square the deltas and the bulge
  always_comb begin
    p2_d.is_arc = p1_q.is_arc;
    p2_d.bneg   = p1_q.bneg;
    p2_d.sx     = p1_q.sx;
    p2_d.sy     = p1_q.sy;
    p2_d.ex     = p1_q.ex;
    p2_d.ey     = p1_q.ey;
    p2_d.midx   = p1_q.midx;
    p2_d.midy   = p1_q.midy;
    p2_d.adx    = p1_q.dx[bsa_pkg::DXW-1] ? -p1_q.dx : p1_q.dx;
    p2_d.ady    = p1_q.dy[bsa_pkg::DXW-1] ? -p1_q.dy : p1_q.dy;
    p2_d.dypos  = p1_q.dy > 0;
    p2_d.dxneg  = p1_q.dx[bsa_pkg::DXW-1];
    p2_d.dx2    = p2_d.adx * p2_d.adx;
    p2_d.dy2    = p2_d.ady * p2_d.ady;
    p2_d.mb     = p1_q.mb;
    p2_d.mb2    = p1_q.mb * p1_q.mb;
  end

  // form the radicand, the offset scale and the divisor
  always_comb begin
    nv           = $signed({1'b0, bsa_pkg::FW'(42'h1_0000_0000)}) -
                   $signed({1'b0, p2_q.mb2});
    nneg         = nv[bsa_pkg::FW];
    sd3_d.is_arc = p2_q.is_arc;
    sd3_d.bneg   = p2_q.bneg;
    sd3_d.sx     = p2_q.sx;
    sd3_d.sy     = p2_q.sy;
    sd3_d.ex     = p2_q.ex;
    sd3_d.ey     = p2_q.ey;
    sd3_d.midx   = p2_q.midx;
    sd3_d.midy   = p2_q.midy;
    sd3_d.adx    = p2_q.adx;
    sd3_d.ady    = p2_q.ady;
    sd3_d.negx   = p2_q.dypos ^ nneg ^ p2_q.bneg;
    sd3_d.negy   = p2_q.dxneg ^ nneg ^ p2_q.bneg;
    sd3_d.nmag   = bsa_pkg::FW'(nneg ? -nv : nv);
    sd3_d.fac    = bsa_pkg::FW'(42'h1_0000_0000) + p2_q.mb2;
    sd3_d.den    = {p2_q.mb, 18'b0};
    sd3_d.rovf   = 1'b0;
  end

  logic [bsa_pkg::SSW-1:0] rsum_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_q   <= p1_d;
      p2_q   <= p2_d;
      sd3_q  <= sd3_d;
      rsum_q <= bsa_pkg::SSW'(p2_q.dx2) + bsa_pkg::SSW'(p2_q.dy2);
    end
  end

  assign sq_init = '{rad: rsum_q, rem: '0, root: '0};

  // ---------------------------------------------------------------- root chain
  bsa_pkg::sqrt_t sq_w [SQW+1];
  bsa_pkg::side_t sqs_q [SQW];

  assign sq_w[0] = sq_init;

  for (genvar k = 0; k < SQW; k++) begin : g_sq
    bsa_sqrt_cell u_cell (
      .clk_i (clk_i),
      .en_i  (adv),
      .st_i  (sq_w[k]),
      .st_o  (sq_w[k+1])
    );
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sqs_q[0] <= sd3_q;
      for (int k = 1; k < SQW; k++) begin
        sqs_q[k] <= sqs_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------- multiply
  m1_t m1_d, m1_q;
  logic [SQW-1:0] len;
  logic [SQW-1:0] adx_e, ady_e;

  // split the 41-bit factors into two slices
  always_comb begin
    len       = sq_w[SQW].root;
    adx_e     = SQW'(sqs_q[SQW-1].adx);
    ady_e     = SQW'(sqs_q[SQW-1].ady);
    m1_d.sd   = sqs_q[SQW-1];
    m1_d.r_lo = len * sqs_q[SQW-1].fac[bsa_pkg::LOW-1:0];
    m1_d.r_hi = len * sqs_q[SQW-1].fac[bsa_pkg::FW-1:bsa_pkg::LOW];
    m1_d.x_lo = ady_e * sqs_q[SQW-1].nmag[bsa_pkg::LOW-1:0];
    m1_d.x_hi = ady_e * sqs_q[SQW-1].nmag[bsa_pkg::FW-1:bsa_pkg::LOW];
    m1_d.y_lo = adx_e * sqs_q[SQW-1].nmag[bsa_pkg::LOW-1:0];
    m1_d.y_hi = adx_e * sqs_q[SQW-1].nmag[bsa_pkg::FW-1:bsa_pkg::LOW];
  end

  bsa_pkg::side_t sd_m2_d, sd_m2_q;
  bsa_pkg::div3_t dv_init_d, dv_init_q;
  logic [bsa_pkg::PW-1:0] n_r, n_x, n_y;

  // sum the slices, check radius range, seed the dividers
  always_comb begin
    n_r = bsa_pkg::PW'(m1_q.r_lo) + {m1_q.r_hi, {bsa_pkg::LOW{1'b0}}};
    n_x = bsa_pkg::PW'(m1_q.x_lo) + {m1_q.x_hi, {bsa_pkg::LOW{1'b0}}};
    n_y = bsa_pkg::PW'(m1_q.y_lo) + {m1_q.y_hi, {bsa_pkg::LOW{1'b0}}};
    sd_m2_d      = m1_q.sd;
    sd_m2_d.rovf = n_r[bsa_pkg::PW-1:bsa_pkg::CW] >=
                   (bsa_pkg::PW - bsa_pkg::CW)'(m1_q.sd.den);
    dv_init_d.r  = '{num: n_r[QW-1:0], rem: bsa_pkg::RW'(n_r[bsa_pkg::PW-1:QW]), q: '0};
    dv_init_d.x  = '{num: n_x[QW-1:0], rem: bsa_pkg::RW'(n_x[bsa_pkg::PW-1:QW]), q: '0};
    dv_init_d.y  = '{num: n_y[QW-1:0], rem: bsa_pkg::RW'(n_y[bsa_pkg::PW-1:QW]), q: '0};
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m1_q      <= m1_d;
      sd_m2_q   <= sd_m2_d;
      dv_init_q <= dv_init_d;
    end
  end

  // ---------------------------------------------------------------- divide chain
  bsa_pkg::div3_t dv_w [QW+1];
  bsa_pkg::side_t dvs_q [QW];

  assign dv_w[0] = dv_init_q;

  for (genvar k = 0; k < QW; k++) begin : g_dv
    bsa_div_cell u_cell (
      .clk_i (clk_i),
      .en_i  (adv),
      .den_i ((k == 0) ? sd_m2_q.den : dvs_q[(k == 0) ? 0 : k-1].den),
      .st_i  (dv_w[k]),
      .st_o  (dv_w[k+1])
    );
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dvs_q[0] <= sd_m2_q;
      for (int k = 1; k < QW; k++) begin
        dvs_q[k] <= dvs_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------- center
  c1_t c1_d, c1_q;
  c2_t c2_d, c2_q;
  bsa_pkg::side_t sdv;
  logic signed [bsa_pkg::CXW-1:0] offx, offy;
  logic [bsa_pkg::CXW-1:0] qx_e, qy_e;
  logic satx, saty;

  // apply the signed offsets to the midpoint
  always_comb begin
    sdv            = dvs_q[QW-1];
    qx_e           = bsa_pkg::CXW'(dv_w[QW].x.q);
    qy_e           = bsa_pkg::CXW'(dv_w[QW].y.q);
    offx           = sdv.negx ? -$signed(qx_e) : $signed(qx_e);
    offy           = sdv.negy ? -$signed(qy_e) : $signed(qy_e);
    c1_d.cxw       = bsa_pkg::CXW'(sdv.midx) + offx;
    c1_d.cyw       = bsa_pkg::CXW'(sdv.midy) + offy;
    c1_d.lt        = '0;
    c1_d.lt.is_arc = sdv.is_arc;
    c1_d.lt.bneg   = sdv.bneg;
    c1_d.lt.sx     = sdv.sx;
    c1_d.lt.sy     = sdv.sy;
    c1_d.lt.ex     = sdv.ex;
    c1_d.lt.ey     = sdv.ey;
    c1_d.lt.rad    = sdv.rovf ? '1 : dv_w[QW].r.q[bsa_pkg::CW-1:0];
    c1_d.lt.ovf    = sdv.rovf;
  end

  // form the center to point vectors, saturate the center
  always_comb begin
    satx = c1_q.cxw[bsa_pkg::CXW-1:bsa_pkg::CW-1] != '0 &&
           c1_q.cxw[bsa_pkg::CXW-1:bsa_pkg::CW-1] != '1;
    saty = c1_q.cyw[bsa_pkg::CXW-1:bsa_pkg::CW-1] != '0 &&
           c1_q.cyw[bsa_pkg::CXW-1:bsa_pkg::CW-1] != '1;
    c2_d.lt     = c1_q.lt;
    c2_d.lt.cx  = satx ? (c1_q.cxw[bsa_pkg::CXW-1] ? 32'sh8000_0000 : 32'sh7fff_ffff)
                       : c1_q.cxw[bsa_pkg::CW-1:0];
    c2_d.lt.cy  = saty ? (c1_q.cyw[bsa_pkg::CXW-1] ? 32'sh8000_0000 : 32'sh7fff_ffff)
                       : c1_q.cyw[bsa_pkg::CW-1:0];
    c2_d.lt.ovf = c1_q.lt.ovf | satx | saty;
    c2_d.vx[0]  = bsa_pkg::VW'(c1_q.lt.sx) - bsa_pkg::VW'(c1_q.cxw);
    c2_d.vy[0]  = bsa_pkg::VW'(c1_q.lt.sy) - bsa_pkg::VW'(c1_q.cyw);
    c2_d.vx[1]  = bsa_pkg::VW'(c1_q.lt.ex) - bsa_pkg::VW'(c1_q.cxw);
    c2_d.vy[1]  = bsa_pkg::VW'(c1_q.lt.ey) - bsa_pkg::VW'(c1_q.cyw);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c1_q <= c1_d;
      c2_q <= c2_d;
    end
  end

  // ---------------------------------------------------------------- normalize
  n1_t n1_d, n1_q;
  n2_t n2_d, n2_q;
  bsa_pkg::cordic2_t cr_init_d, cr_init_q;
  bsa_pkg::late_t    lt3_d, lt3_q;
  logic [bsa_pkg::VMW-1:0] orv [2];
  logic [1:0][bsa_pkg::NMW-1:0] ax_s, ay_s;
  bsa_pkg::cordic_t cl [2];

  // split vectors into magnitude and sign
  always_comb begin
    n1_d.lt = c2_q.lt;
    for (int v = 0; v < 2; v++) begin
      n1_d.xn[v] = c2_q.vx[v][bsa_pkg::VW-1];
      n1_d.yn[v] = c2_q.vy[v][bsa_pkg::VW-1];
      n1_d.ax[v] = bsa_pkg::VMW'(n1_d.xn[v] ? -c2_q.vx[v] : c2_q.vx[v]);
      n1_d.ay[v] = bsa_pkg::VMW'(n1_d.yn[v] ? -c2_q.vy[v] : c2_q.vy[v]);
    end
  end

  // find the leading one of the larger magnitude
  always_comb begin
    n2_d.lt = n1_q.lt;
    n2_d.ax = n1_q.ax;
    n2_d.ay = n1_q.ay;
    n2_d.xn = n1_q.xn;
    n2_d.yn = n1_q.yn;
    for (int v = 0; v < 2; v++) begin
      orv[v]      = n1_q.ax[v] | n1_q.ay[v];
      n2_d.pos[v] = '0;
      for (int j = 0; j < bsa_pkg::VMW; j++) begin
        if (orv[v][j]) begin
          n2_d.pos[v] = bsa_pkg::PSW'(j);
        end
      end
      n2_d.lt.zero[v] = orv[v] == '0;
    end
  end

  // scale into the rotator range and fold the left half plane
  always_comb begin
    lt3_d = n2_q.lt;
    for (int v = 0; v < 2; v++) begin
      if (n2_q.pos[v] >= bsa_pkg::PSW'(bsa_pkg::NORM_MSB)) begin
        ax_s[v] = bsa_pkg::NMW'(n2_q.ax[v] >> (n2_q.pos[v] - bsa_pkg::PSW'(bsa_pkg::NORM_MSB)));
        ay_s[v] = bsa_pkg::NMW'(n2_q.ay[v] >> (n2_q.pos[v] - bsa_pkg::PSW'(bsa_pkg::NORM_MSB)));
      end else begin
        ax_s[v] = bsa_pkg::NMW'(n2_q.ax[v] << (bsa_pkg::PSW'(bsa_pkg::NORM_MSB) - n2_q.pos[v]));
        ay_s[v] = bsa_pkg::NMW'(n2_q.ay[v] << (bsa_pkg::PSW'(bsa_pkg::NORM_MSB) - n2_q.pos[v]));
      end
      lt3_d.flip[v] = n2_q.xn[v] && ax_s[v] != '0;
      cl[v].px = $signed(bsa_pkg::CRW'(ax_s[v]));
      cl[v].py = (n2_q.yn[v] ^ lt3_d.flip[v]) ? -$signed(bsa_pkg::CRW'(ay_s[v]))
                                              : $signed(bsa_pkg::CRW'(ay_s[v]));
      cl[v].z  = '0;
    end
    cr_init_d.s = cl[0];
    cr_init_d.e = cl[1];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      n1_q      <= n1_d;
      n2_q      <= n2_d;
      lt3_q     <= lt3_d;
      cr_init_q <= cr_init_d;
    end
  end

  // ---------------------------------------------------------------- rotator chain
  bsa_pkg::cordic2_t cr_w [NS+1];
  bsa_pkg::late_t    crs_q [NS];

  assign cr_w[0] = cr_init_q;

  for (genvar k = 0; k < NS; k++) begin : g_cr
    bsa_cordic_cell #(.STEP(k)) u_cell (
      .clk_i (clk_i),
      .en_i  (adv),
      .st_i  (cr_w[k]),
      .st_o  (cr_w[k+1])
    );
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      crs_q[0] <= lt3_q;
      for (int k = 1; k < NS; k++) begin
        crs_q[k] <= crs_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------- output
  bsa_pkg::late_t lf;
  logic signed [bsa_pkg::ZW-1:0] za [2];
  logic signed [bsa_pkg::ZW-1:0] a0 [2];
  logic signed [bsa_pkg::ZW-1:0] a1 [2];
  logic signed [bsa_pkg::ZW-1:0] a2 [2];

  // wrap angles into one period, clear arc fields for lines
  always_comb begin
    lf    = crs_q[NS-1];
    za[0] = cr_w[NS].s.z;
    za[1] = cr_w[NS].e.z;
    for (int v = 0; v < 2; v++) begin
      a0[v] = za[v] + (lf.flip[v] ? bsa_pkg::ANG_PI : '0);
      a1[v] = (a0[v] < 0) ? a0[v] + bsa_pkg::ANG_TWO_PI : a0[v];
      a2[v] = (a1[v] >= bsa_pkg::ANG_TWO_PI) ? a1[v] - bsa_pkg::ANG_TWO_PI : a1[v];
      if (lf.zero[v]) begin
        a2[v] = '0;
      end
    end
    out_d.is_arc = lf.is_arc;
    out_d.sx     = lf.sx;
    out_d.sy     = lf.sy;
    out_d.ex     = lf.ex;
    out_d.ey     = lf.ey;
    out_d.cx     = lf.is_arc ? lf.cx : '0;
    out_d.cy     = lf.is_arc ? lf.cy : '0;
    out_d.rad    = lf.is_arc ? lf.rad : '0;
    out_d.sa     = lf.is_arc ? a2[0][bsa_pkg::AW-1:0] : '0;
    out_d.ea     = lf.is_arc ? a2[1][bsa_pkg::AW-1:0] : '0;
    out_d.rev    = lf.is_arc && lf.bneg;
    out_d.ovf    = lf.is_arc && lf.ovf;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign arc_o.valid       = out_vld_q;
  assign arc_o.is_arc      = out_q.is_arc;
  assign arc_o.seg_start_x = out_q.sx;
  assign arc_o.seg_start_y = out_q.sy;
  assign arc_o.seg_end_x   = out_q.ex;
  assign arc_o.seg_end_y   = out_q.ey;
  assign arc_o.center_x    = out_q.cx;
  assign arc_o.center_y    = out_q.cy;
  assign arc_o.radius      = out_q.rad;
  assign arc_o.start_angle = out_q.sa;
  assign arc_o.end_angle   = out_q.ea;
  assign arc_o.reversed    = out_q.rev;
  assign arc_o.overflow    = out_q.ovf;

  // ---------------------------------------------------------------- checks
  a_line_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    arc_o.valid && !arc_o.is_arc |-> arc_o.radius == '0 && arc_o.center_x == '0 &&
      arc_o.center_y == '0 && !arc_o.overflow && !arc_o.reversed)
    else $error("line word carries arc fields");

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    arc_o.valid |-> arc_o.start_angle < bsa_pkg::AW'(bsa_pkg::ANG_TWO_PI) &&
      arc_o.end_angle < bsa_pkg::AW'(bsa_pkg::ANG_TWO_PI))
    else $error("angle outside one period");

  a_stall_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    arc_o.valid && !arc_o.ready |-> !seg_i.ready)
    else $error("input taken while output stalled");

  a_pipe_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> vld_q == $past(vld_q))
    else $error("pipe moved during stall");

endmodule
`default_nettype wire

// ----- hdl/bsa_sqrt_cell.sv -----
`default_nettype none
// One bit of the integer square root: bring down two radicand bits, try root*4+1.
module bsa_sqrt_cell (
  input  logic           clk_i,
  input  logic           en_i,
  input  bsa_pkg::sqrt_t st_i,
  output bsa_pkg::sqrt_t st_o
);

  bsa_pkg::sqrt_t st_d, st_q;
  logic [bsa_pkg::REMW-1:0] rem2;
  logic [bsa_pkg::REMW-1:0] trial;
  logic                     ge;

  always_comb begin
    rem2       = {st_i.rem[bsa_pkg::REMW-3:0], st_i.rad[bsa_pkg::SSW-1 -: 2]};
    trial      = {1'b0, st_i.root, 2'b01};
    ge         = rem2 >= trial;
    st_d.rem   = ge ? rem2 - trial : rem2;
    st_d.root  = {st_i.root[bsa_pkg::SQW-2:0], ge};
    st_d.rad   = {st_i.rad[bsa_pkg::SSW-3:0], 2'b00};
  end

  // advance with the pipe
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q <= st_d;
    end
  end

  assign st_o = st_q;

endmodule
`default_nettype wire

// ----- hdl/bsa_div_cell.sv -----
`default_nettype none
// One quotient bit of three restoring divisions that share a divisor.
module bsa_div_cell (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [bsa_pkg::DW-1:0]   den_i,
  input  bsa_pkg::div3_t           st_i,
  output bsa_pkg::div3_t           st_o
);

  bsa_pkg::div3_t st_d, st_q;

  function automatic bsa_pkg::div_t div_step(input bsa_pkg::div_t s,
                                             input logic [bsa_pkg::DW-1:0] d);
    bsa_pkg::div_t n;
    logic [bsa_pkg::RW-1:0] r2;
    logic [bsa_pkg::RW-1:0] dd;
    logic ge;
    r2    = {s.rem[bsa_pkg::RW-2:0], s.num[bsa_pkg::QW-1]};
    dd    = {1'b0, d};
    ge    = r2 >= dd;
    n.rem = ge ? r2 - dd : r2;
    n.q   = {s.q[bsa_pkg::QW-2:0], ge};
    n.num = {s.num[bsa_pkg::QW-2:0], 1'b0};
    return n;
  endfunction

  always_comb begin
    st_d.r = div_step(st_i.r, den_i);
    st_d.x = div_step(st_i.x, den_i);
    st_d.y = div_step(st_i.y, den_i);
  end

  // advance with the pipe
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q <= st_d;
    end
  end

  assign st_o = st_q;

endmodule
`default_nettype wire

// ----- hdl/bsa_cordic_cell.sv -----
`default_nettype none
// One vectoring rotation step for the start and end vectors.
module bsa_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  bsa_pkg::cordic2_t st_i,
  output bsa_pkg::cordic2_t st_o
);

  localparam logic [bsa_pkg::ATW-1:0] ATAN = bsa_pkg::atan_val(STEP);

  bsa_pkg::cordic2_t st_d, st_q;

  // shift toward zero, as a magnitude with the sign put back
  function automatic logic signed [bsa_pkg::CRW-1:0] shr_tz(
      input logic signed [bsa_pkg::CRW-1:0] v);
    logic [bsa_pkg::CRW-1:0] m;
    logic [bsa_pkg::CRW-1:0] s;
    m = v[bsa_pkg::CRW-1] ? -v : v;
    s = m >> STEP;
    return v[bsa_pkg::CRW-1] ? -$signed(s) : $signed(s);
  endfunction

  function automatic bsa_pkg::cordic_t rot(input bsa_pkg::cordic_t c);
    bsa_pkg::cordic_t n;
    logic signed [bsa_pkg::CRW-1:0] dx;
    logic signed [bsa_pkg::CRW-1:0] dy;
    logic signed [bsa_pkg::ZW-1:0]  at;
    dx = shr_tz(c.py);
    dy = shr_tz(c.px);
    at = $signed({{(bsa_pkg::ZW - bsa_pkg::ATW){1'b0}}, ATAN});
    if (c.py > 0) begin
      n.px = c.px + dx;
      n.py = c.py - dy;
      n.z  = c.z + at;
    end else begin
      n.px = c.px - dx;
      n.py = c.py + dy;
      n.z  = c.z - at;
    end
    return n;
  endfunction

  always_comb begin
    st_d.s = rot(st_i.s);
    st_d.e = rot(st_i.e);
  end

  // advance with the pipe
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q <= st_d;
    end
  end

  assign st_o = st_q;

endmodule
`default_nettype wire

// ----- sim/tb_bulge_segment_to_arc.sv -----
`timescale 1ns / 1ps
module tb_bulge_segment_to_arc;

  localparam int  HALF_PERIOD  = 2;
  localparam int  DRAIN_CYCLES = 130;
  localparam int  HOLD_CYCLES  = 400;
  localparam int  ITEMS_PER_PH = 80;
  localparam longint CYCLE_LIMIT = 3000000;
  localparam longint PI_Q28     = 843314857;
  localparam longint TWO_PI_Q28 = 1686629713;

  // arctan(2^-i), Q3.28
  localparam longint ATAN_Q28 [28] = '{
    210828714, 124459457, 65760959, 33381290, 16755422, 8385879,
    4193963, 2097109, 1048571, 524287, 262144, 131072,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2};

  typedef struct packed {
    logic signed [bsa_pkg::CW-1:0] ax;
    logic signed [bsa_pkg::CW-1:0] ay;
    logic signed [bsa_pkg::CW-1:0] vx;
    logic signed [bsa_pkg::CW-1:0] vy;
    logic signed [bsa_pkg::BW-1:0] bulge;
    logic                          pre;
  } segment_t;

  typedef struct packed {
    segment_t      seg;
    logic          typed;
    bsa_pkg::res_t arc;
  } seg_row_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_we_i = 1'b0;
  logic [bsa_pkg::TOLW-1:0] cfg_wdata_i = '0;
  logic [bsa_pkg::TOLW-1:0] tol_q = bsa_pkg::TOL_RESET;

  bsa_seg_if seg_if ();
  bsa_arc_if arc_if ();

  bsa_pkg::res_t arc_queue[$];
  seg_row_t      rows[$];
  logic          typed_word;
  bsa_pkg::res_t typed_arc;
  int            fails = 0;
  longint        cycles = 0;
  logic          hold_req = 1'b0;
  logic          idle_on = 1'b1;

  bulge_segment_to_arc dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .seg_i       (seg_if.sink),
    .arc_o       (arc_if.source)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // direction of (x, y) in Q3.28 via a prescaled rotator
  function automatic logic [bsa_pkg::AW-1:0] heading(longint x, longint y);
    longint unsigned mx, my, mm;
    longint px, py, z, base, a, sx, sy;
    int i;
    if (x == 0 && y == 0) return '0;
    mx = (x < 0) ? -x : x;
    my = (y < 0) ? -y : y;
    mm = (mx > my) ? mx : my;
    while (mm >= 64'd1 << 30) begin
      mx >>= 1; my >>= 1; mm >>= 1;
    end
    while (mm < 64'd1 << 29) begin
      mx <<= 1; my <<= 1; mm <<= 1;
    end
    px = (x < 0) ? -longint'(mx) : longint'(mx);
    py = (y < 0) ? -longint'(my) : longint'(my);
    z = 0;
    base = 0;
    if (px < 0) begin
      px = -px; py = -py; base = PI_Q28;
    end
    for (i = 0; i < 28; i++) begin
      sx = (py < 0) ? -((-py) >>> i) : (py >>> i);
      sy = (px < 0) ? -((-px) >>> i) : (px >>> i);
      if (py > 0) begin
        px += sx; py -= sy; z += ATAN_Q28[i];
      end else begin
        px -= sx; py += sy; z -= ATAN_Q28[i];
      end
    end
    a = base + z;
    if (a < 0) a += TWO_PI_Q28;
    if (a >= TWO_PI_Q28) a -= TWO_PI_Q28;
    return a[bsa_pkg::AW-1:0];
  endfunction

  function automatic longint clamp32(longint v, ref logic ovf);
    if (v > 64'sd2147483647) begin
      ovf = 1'b1; return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      ovf = 1'b1; return -64'sd2147483648;
    end
    return v;
  endfunction

  // expected arc or line for one segment under the current tolerance
  function automatic bsa_pkg::res_t arc_of(segment_t s, logic [bsa_pkg::TOLW-1:0] tol);
    bsa_pkg::res_t r;
    longint sx, sy, ex, ey, dx, dy, b, nval, cx, cy, offx, offy;
    longint unsigned mb, adx, ady, nmag;
    logic [127:0] ss, len, t, den, radw;
    logic ovf, bneg, negx, negy;
    int k;
    r = '0;
    sx = s.pre ? s.vx : s.ax;
    sy = s.pre ? s.vy : s.ay;
    ex = s.pre ? s.ax : s.vx;
    ey = s.pre ? s.ay : s.vy;
    r.sx = sx[bsa_pkg::CW-1:0]; r.sy = sy[bsa_pkg::CW-1:0];
    r.ex = ex[bsa_pkg::CW-1:0]; r.ey = ey[bsa_pkg::CW-1:0];
    b = s.bulge;
    bneg = b < 0;
    mb = bneg ? -b : b;
    if (mb < tol || mb == 0) return r;
    dx = ex - sx;
    dy = ey - sy;
    adx = (dx < 0) ? -dx : dx;
    ady = (dy < 0) ? -dy : dy;
    ss = 128'(adx) * 128'(adx) + 128'(ady) * 128'(ady);
    len = '0;
    for (k = 33; k >= 0; k--) begin
      t = len | (128'd1 << k);
      if (t * t <= ss) len = t;
    end
    den = 128'(mb) << 18;
    radw = (len * ((128'd1 << 32) + 128'(mb) * 128'(mb))) / den;
    ovf = 1'b0;
    if (radw > 128'hFFFF_FFFF) begin
      radw = 128'hFFFF_FFFF; ovf = 1'b1;
    end
    nval = (64'sd1 <<< 32) - longint'(mb * mb);
    nmag = (nval < 0) ? -nval : nval;
    offx = longint'((128'(ady) * 128'(nmag)) / den);
    offy = longint'((128'(adx) * 128'(nmag)) / den);
    negx = (dy > 0) ^ (nval < 0) ^ bneg;
    negy = (dx < 0) ^ (nval < 0) ^ bneg;
    cx = (sx + ex) / 2 + (negx ? -offx : offx);
    cy = (sy + ey) / 2 + (negy ? -offy : offy);
    r.is_arc = 1'b1;
    r.sa = heading(sx - cx, sy - cy);
    r.ea = heading(ex - cx, ey - cy);
    r.cx = bsa_pkg::CW'(clamp32(cx, ovf));
    r.cy = bsa_pkg::CW'(clamp32(cy, ovf));
    r.rad = radw[bsa_pkg::CW-1:0];
    r.rev = bneg;
    r.ovf = ovf;
    return r;
  endfunction

  function automatic bsa_pkg::res_t line_of(segment_t s);
    bsa_pkg::res_t r;
    r = '0;
    r.sx = s.pre ? s.vx : s.ax;
    r.sy = s.pre ? s.vy : s.ay;
    r.ex = s.pre ? s.ax : s.vx;
    r.ey = s.pre ? s.ay : s.vy;
    return r;
  endfunction

  function automatic int gap_cycles();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic segment_t random_segment(logic [bsa_pkg::TOLW-1:0] tol);
    segment_t s;
    int mode;
    s.ax = $urandom; s.ay = $urandom;
    s.vx = $urandom; s.vy = $urandom;
    mode = $urandom_range(0, 9);
    if (mode < 5) begin
      // keep about half of the segments in a drawing-sized window
      s.ax = $signed($urandom_range(0, 2 ** 24)) - 2 ** 23;
      s.ay = $signed($urandom_range(0, 2 ** 24)) - 2 ** 23;
      s.vx = s.ax + $signed($urandom_range(0, 2 ** 22)) - 2 ** 21;
      s.vy = s.ay + $signed($urandom_range(0, 2 ** 22)) - 2 ** 21;
    end else if (mode == 5) begin
      s.vx = s.ax; s.vy = s.ay;
    end
    mode = $urandom_range(0, 9);
    case (mode)
      0: s.bulge = '0;
      1: s.bulge = bsa_pkg::BW'($signed(21'(tol)) + $signed($urandom_range(0, 4)) - 2);
      2: s.bulge = bsa_pkg::BW'(-($signed(21'(tol)) + $signed($urandom_range(0, 4)) - 2));
      3: s.bulge = bsa_pkg::BW'($signed($urandom_range(0, 8)) - 4);
      4: s.bulge = $urandom_range(0, 1) ? 21'h0FFFFF : 21'h100000;
      default: s.bulge = bsa_pkg::BW'($urandom);
    endcase
    s.pre = 1'($urandom_range(0, 1));
    return s;
  endfunction

  // present one word and hold it until taken, then maybe idle
  task automatic send_word(segment_t s, logic typed, bsa_pkg::res_t arc);
    @(negedge clk_i);
    seg_if.valid = 1'b1;
    seg_if.anchor_x = s.ax; seg_if.anchor_y = s.ay;
    seg_if.vertex_x = s.vx; seg_if.vertex_y = s.vy;
    seg_if.bulge = s.bulge; seg_if.prepend = s.pre;
    typed_word = typed;
    typed_arc = arc;
    do @(posedge clk_i); while (!seg_if.ready);
    repeat (gap_cycles()) begin
      @(negedge clk_i);
      seg_if.valid = 1'b0;
    end
  endtask

  task automatic write_tol(logic [bsa_pkg::TOLW-1:0] v);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_wdata_i = v;
    @(posedge clk_i);
    tol_q = v;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic drain();
    @(negedge clk_i);
    seg_if.valid = 1'b0;
    wait (arc_queue.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // record accepted words, check delivered results
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (seg_if.valid && seg_if.ready) begin
      arc_queue.insert(arc_queue.size(), typed_word ? typed_arc :
        arc_of({seg_if.anchor_x, seg_if.anchor_y, seg_if.vertex_x, seg_if.vertex_y,
                seg_if.bulge, seg_if.prepend}, tol_q));
    end
    if (arc_if.valid && arc_if.ready) begin
      if (arc_queue.size() == 0) begin
        $error("result word with nothing expected");
        fails++;
      end else begin
        bsa_pkg::res_t e;
        e = arc_queue.pop_front();
        if (arc_if.is_arc !== e.is_arc) begin
          $error("is_arc exp %0d got %0d", e.is_arc, arc_if.is_arc); fails++;
        end
        if (arc_if.seg_start_x !== e.sx) begin
          $error("seg_start_x exp %0d got %0d", e.sx, arc_if.seg_start_x); fails++;
        end
        if (arc_if.seg_start_y !== e.sy) begin
          $error("seg_start_y exp %0d got %0d", e.sy, arc_if.seg_start_y); fails++;
        end
        if (arc_if.seg_end_x !== e.ex) begin
          $error("seg_end_x exp %0d got %0d", e.ex, arc_if.seg_end_x); fails++;
        end
        if (arc_if.seg_end_y !== e.ey) begin
          $error("seg_end_y exp %0d got %0d", e.ey, arc_if.seg_end_y); fails++;
        end
        if (arc_if.center_x !== e.cx) begin
          $error("center_x exp %0d got %0d", e.cx, arc_if.center_x); fails++;
        end
        if (arc_if.center_y !== e.cy) begin
          $error("center_y exp %0d got %0d", e.cy, arc_if.center_y); fails++;
        end
        if (arc_if.radius !== e.rad) begin
          $error("radius exp %0d got %0d", e.rad, arc_if.radius); fails++;
        end
        if (arc_if.start_angle !== e.sa) begin
          $error("start_angle exp %0d got %0d", e.sa, arc_if.start_angle); fails++;
        end
        if (arc_if.end_angle !== e.ea) begin
          $error("end_angle exp %0d got %0d", e.ea, arc_if.end_angle); fails++;
        end
        if (arc_if.reversed !== e.rev) begin
          $error("reversed exp %0d got %0d", e.rev, arc_if.reversed); fails++;
        end
        if (arc_if.overflow !== e.ovf) begin
          $error("overflow exp %0d got %0d", e.ovf, arc_if.overflow); fails++;
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_bulge_segment_to_arc failed");
      $finish;
    end
  end

  // drive ready with random stalls; honor a requested long hold-off
  initial begin
    arc_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        arc_if.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end
      arc_if.ready = 1'b1;
      repeat (gap_cycles()) begin
        @(negedge clk_i);
        arc_if.ready = 1'b0;
      end
    end
  end

  initial begin
    segment_t s;
    seg_row_t row;
    logic [bsa_pkg::TOLW-1:0] tol_set [5];
    int ph, n;
    seg_if.valid = 1'b0;
    seg_if.anchor_x = '0; seg_if.anchor_y = '0;
    seg_if.vertex_x = '0; seg_if.vertex_y = '0;
    seg_if.bulge = '0; seg_if.prepend = 1'b0;
    typed_word = 1'b0;
    typed_arc = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed rows: lines typed in, arcs left to the predictor
    rows.insert(rows.size(),
      '{'{32'sh10000, 32'sh20000, 32'sh30000, 32'sh40000, '0, 1'b0}, 1'b1, '0});
    rows.insert(rows.size(),
      '{'{32'sh10000, 32'sh20000, 32'sh30000, 32'sh40000, '0, 1'b1}, 1'b1, '0});
    rows.insert(rows.size(),
      '{'{32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, '0, 1'b0}, 1'b1, '0});
    rows.insert(rows.size(),
      '{'{32'hFFFFFFFF, 32'h0, 32'h0, 32'hFFFFFFFF, '0, 1'b1}, 1'b1, '0});
    rows.insert(rows.size(),
      '{'{32'sh0, 32'sh0, 32'sh20000, 32'sh0, 21'sd1, 1'b0}, 1'b0, '0});
    rows.insert(rows.size(),
      '{'{32'sh0, 32'sh0, 32'sh20000, 32'sh0, -21'sd1, 1'b0}, 1'b0, '0});
    rows.insert(rows.size(),
      '{'{32'sh0, 32'sh0, 32'sh20000, 32'sh0, 21'sd65536, 1'b0}, 1'b0, '0});
    rows.insert(rows.size(),
      '{'{32'sh0, 32'sh0, 32'sh20000, 32'sh0, -21'sd65536, 1'b1}, 1'b0, '0});
    rows.insert(rows.size(),
      '{'{32'sh10000, 32'sh0, 32'sh0, 32'sh10000, 21'sd32768, 1'b0}, 1'b0, '0});
    rows.insert(rows.size(),
      '{'{32'sh10000, 32'sh0, 32'sh0, 32'sh10000, 21'h0FFFFF, 1'b0}, 1'b0, '0});
    rows.insert(rows.size(),
      '{'{32'sh10000, 32'sh0, 32'sh0, 32'sh10000, 21'h100000, 1'b1}, 1'b0, '0});
    rows.insert(rows.size(),
      '{'{32'sh50000, 32'sh50000, 32'sh50000, 32'sh50000, 21'sd65536, 1'b0}, 1'b0, '0});
    rows.insert(rows.size(),
      '{'{32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 21'sd1, 1'b0},
        1'b0, '0});
    rows.insert(rows.size(),
      '{'{32'h70000000, 32'h0, 32'h7FFFFFFF, 32'h0, 21'h0FFFFF, 1'b0}, 1'b0, '0});
    rows.insert(rows.size(),
      '{'{32'h80000000, 32'h0, 32'h90000000, 32'h0, 21'sd4, 1'b1}, 1'b0, '0});
    rows.insert(rows.size(),
      '{'{32'sh0, 32'sh0, 32'sh0, -32'sh30000, 21'sd131072, 1'b0}, 1'b0, '0});
    foreach (rows[i]) begin
      row = rows[i];
      if (row.typed) row.arc = line_of(row.seg);
      send_word(row.seg, row.typed, row.arc);
    end
    drain();

    // random phases over several tolerance settings
    tol_set = '{bsa_pkg::TOL_RESET, 17'd0, 17'd65536, 17'd300, 17'd1};
    tol_set[4] = bsa_pkg::TOLW'($urandom_range(0, 65536));
    for (ph = 0; ph < 5; ph++) begin
      if (ph > 0) write_tol(tol_set[ph]);
      if (ph == 1) begin
        // zero bulge under zero tolerance still gives a line
        send_word('{32'sh10000, 32'sh0, 32'sh0, 32'sh0, '0, 1'b0}, 1'b0, '0);
      end
      idle_on = (ph != 2);
      if (ph == 1) hold_req = 1'b1;
      for (n = 0; n < ITEMS_PER_PH; n++) begin
        s = random_segment(tol_q);
        send_word(s, 1'b0, '0);
      end
      drain();
    end

    if (fails == 0) begin
      $display("tb_bulge_segment_to_arc passed");
    end else begin
      $display("tb_bulge_segment_to_arc failed");
    end
    $finish;
  end

endmodule
